// ----- src/rol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rol_pkg
// shared types and constants of the request outcome ledger
// ----------------------------------------------------------------------------
package rol_pkg;

	localparam int DEF_ENTRIES = 64;
	localparam int ID_W        = 64;
	localparam int PIECE_W     = 32;
	localparam int OUTC_W      = 3;
	localparam int KIND_W      = 3;
	localparam int COUNT_W     = 32;
	localparam int IN_DATA_W   = 136;
	localparam int OUT_DATA_W  = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_BEGIN      = 3'd0,
		KIND_FINISH     = 3'd1,
		KIND_REPLACE    = 3'd2,
		KIND_INVALIDATE = 3'd3,
		KIND_QUERY      = 3'd4
	} kind_t;

	localparam logic [OUTC_W-1:0] OUTC_ACTIVE   = 3'd0;
	localparam logic [OUTC_W-1:0] OUTC_REPLACED = 3'd4;
	localparam logic [OUTC_W-1:0] OUTC_CORRUPT  = 3'd5;
	localparam logic [OUTC_W-1:0] OUTC_LAST     = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PIECE_W-1:0] piece;
		logic [OUTC_W-1:0]  outcome;
	} entry_t;

	typedef struct packed {
		kind_t              kind;
		logic [ID_W-1:0]    id;
		logic [PIECE_W-1:0] piece;
		logic [PIECE_W-1:0] piece_end;
		logic [OUTC_W-1:0]  new_outcome;
	} op_t;

	typedef struct packed {
		logic              id_hit;
		logic              upd;
		logic              inc;
		logic [OUTC_W-1:0] outcome;
	} match_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               terminal_count;
		logic [OUTC_W-1:0]  stored_outcome;
		logic               found;
		logic               ok;
	} result_t;

endpackage

// ----- src/rol_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rol_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/rol_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rol_match
// shared compare unit: checks one table entry against the current operation
// ----------------------------------------------------------------------------
module rol_match (
	input  rol_pkg::entry_t ent,
	input  rol_pkg::op_t    op,
	output rol_pkg::match_t res
);

	logic active;
	logic id_eq;
	logic in_range;
	logic newo_ok;

	assign active   = (ent.outcome == rol_pkg::OUTC_ACTIVE);
	assign id_eq    = (ent.id == op.id);
	assign in_range = (ent.piece >= op.piece) && (ent.piece < op.piece_end);
	assign newo_ok  = (op.new_outcome != rol_pkg::OUTC_ACTIVE) &&
	                  (op.new_outcome <= rol_pkg::OUTC_LAST);

	always_comb begin
		res         = '0;
		res.id_hit  = id_eq;
		res.outcome = ent.outcome;
		unique case (op.kind)
			rol_pkg::KIND_FINISH: begin
				res.upd     = id_eq && active && newo_ok;
				res.outcome = op.new_outcome;
			end
			rol_pkg::KIND_REPLACE: begin
				res.upd     = (ent.piece == op.piece) && active;
				res.inc     = res.upd;
				res.outcome = rol_pkg::OUTC_REPLACED;
			end
			rol_pkg::KIND_INVALIDATE: begin
				res.upd     = in_range && active;
				res.outcome = rol_pkg::OUTC_CORRUPT;
			end
			default: begin
				res.upd = 1'b0;
			end
		endcase
	end

endmodule

// ----- src/request_outcome_ledger_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_outcome_ledger_core
// table of outstanding requests, scanned one entry per cycle by a shared
// compare unit under a small sequencer
// an accepted item is checked against every used entry, then its result is
// registered once the output is free; an unused kind skips the scan
// a new item is accepted only once the previous result is registered; the
// scan is bounded by the table ram's single read port (one read per cycle)
// reset clears the fill count and sequencer; ram contents are never read
// beyond the fill count, so no clearing pass is needed
// ----------------------------------------------------------------------------
module request_outcome_ledger_core #(
	parameter int ENTRIES = rol_pkg::DEF_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// request_id, piece, piece_end, new_outcome, zero pad
	input  logic [rol_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [rol_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// ok, found, stored_outcome, terminal_count, count, zero pad
	output logic [rol_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ENT_W = $bits(rol_pkg::entry_t);

	rol_pkg::state_t  state_q, state_d;
	rol_pkg::op_t     op_q;
	rol_pkg::entry_t  rd_ent;
	rol_pkg::entry_t  wr_ent;
	rol_pkg::match_t  res;
	rol_pkg::result_t result;
	rol_pkg::result_t out_q;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] rd_q;
	logic [CNT_W-1:0] rep_cnt_q;
	logic [IDX_W-1:0] idx_s1;
	logic             pend_s1;
	logic             hit_q;
	logic [rol_pkg::OUTC_W-1:0] hit_out_q;
	logic             fin_ok_q;
	logic             out_valid_q;

	logic             accept;
	logic             issue;
	logic             scan_done;
	logic             final_go;
	logic             full;
	logic             ins;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENT_W-1:0] ram_rdata;
	logic             known_kind;

	assign full       = (fill_q == CNT_W'(ENTRIES));
	assign known_kind = (s_axis_tuser <= rol_pkg::KIND_QUERY);
	assign rd_ent     = rol_pkg::entry_t'(ram_rdata);

	rol_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_ent),
		.re    (issue),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	rol_match u_match (
		.ent (rd_ent),
		.op  (op_q),
		.res (res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rol_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = known_kind ? rol_pkg::ST_SCAN : rol_pkg::ST_FINAL;
				end
			end
			rol_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = rol_pkg::ST_FINAL;
				end
			end
			rol_pkg::ST_FINAL: begin
				if (final_go) begin
					state_d = rol_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rol_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == rol_pkg::ST_IDLE);
		accept        = s_axis_tvalid && s_axis_tready;
		issue         = (state_q == rol_pkg::ST_SCAN) && (rd_q < fill_q);
		scan_done     = (state_q == rol_pkg::ST_SCAN) && !pend_s1 && !issue;
		final_go      = (state_q == rol_pkg::ST_FINAL) && (!out_valid_q || m_axis_tready);
		ins           = final_go && (op_q.kind == rol_pkg::KIND_BEGIN) && !hit_q && !full;
		ram_we        = (pend_s1 && res.upd) || ins;
		if (ins) begin
			ram_waddr      = fill_q[IDX_W-1:0];
			wr_ent.id      = op_q.id;
			wr_ent.piece   = op_q.piece;
			wr_ent.outcome = rol_pkg::OUTC_ACTIVE;
		end else begin
			ram_waddr      = idx_s1;
			wr_ent.id      = rd_ent.id;
			wr_ent.piece   = rd_ent.piece;
			wr_ent.outcome = res.outcome;
		end
	end

	// result of the finished operation
	always_comb begin
		result    = '0;
		result.ok = 1'b1;
		unique case (op_q.kind)
			rol_pkg::KIND_BEGIN: begin
				result.ok = !hit_q && !full;
			end
			rol_pkg::KIND_FINISH: begin
				result.ok = fin_ok_q;
			end
			rol_pkg::KIND_REPLACE: begin
				result.count = rol_pkg::COUNT_W'(rep_cnt_q);
			end
			rol_pkg::KIND_INVALIDATE: begin
				if (op_q.piece_end > op_q.piece) begin
					result.count = op_q.piece_end - op_q.piece;
				end
			end
			rol_pkg::KIND_QUERY: begin
				result.found          = hit_q;
				result.stored_outcome = hit_out_q;
				result.terminal_count = hit_q && (hit_out_q != rol_pkg::OUTC_ACTIVE);
			end
			default: begin
				result.ok = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rol_pkg::ST_IDLE;
			fill_q      <= '0;
			rd_q        <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (accept) begin
				rd_q <= '0;
			end else if (issue) begin
				rd_q <= rd_q + 1'b1;
			end
			if (ins) begin
				fill_q <= fill_q + 1'b1;
			end
			if (final_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation and scan payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDX_W-1:0];
		if (accept) begin
			op_q.kind        <= rol_pkg::kind_t'(s_axis_tuser);
			op_q.id          <= s_axis_tdata[63:0];
			op_q.piece       <= s_axis_tdata[95:64];
			op_q.piece_end   <= s_axis_tdata[127:96];
			op_q.new_outcome <= s_axis_tdata[130:128];
			hit_q            <= 1'b0;
			hit_out_q        <= rol_pkg::OUTC_ACTIVE;
			fin_ok_q         <= 1'b0;
			rep_cnt_q        <= '0;
		end else if (pend_s1) begin
			if (res.id_hit) begin
				hit_q     <= 1'b1;
				hit_out_q <= rd_ent.outcome;
			end
			if ((op_q.kind == rol_pkg::KIND_FINISH) && res.upd) begin
				fin_ok_q <= 1'b1;
			end
			if (res.inc) begin
				rep_cnt_q <= rep_cnt_q + 1'b1;
			end
		end
		if (final_go) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

endmodule
